@@ src/bcl_pkg.sv @@
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the button click / long-press detector.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int COUNT_BITS_DEFAULT = 8;
  localparam int CFG_INDEX_BITS     = 4;
  localparam int CFG_DATA_BITS      = 16;
  localparam int TIME_BITS          = 32;
  localparam int OUT_COUNT_BITS     = 8;

  localparam logic [CFG_DATA_BITS-1:0] CLICK_WINDOW_RESET = 16'd300;
  localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [CFG_DATA_BITS-1:0] REPEAT_RESET       = 16'd100;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLED      = 4'd0,
    REG_CLICK_WINDOW = 4'd1,
    REG_LONG_PRESS   = 4'd2,
    REG_REPEAT       = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 pin_level;
    logic [TIME_BITS-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic                      changed;
    logic                      pressed;
    logic [OUT_COUNT_BITS-1:0] press_count;
    logic [OUT_COUNT_BITS-1:0] click_count;
    logic                      long_pressed;
    logic                      repeated;
  } status_t;

endpackage

@@ src/bcl_stream_if.sv @@
// ----------------------------------------------------------------------------
// bcl_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bcl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/button_click_long_press_detector.sv @@
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// An accepted sample transaction gives its registered status in the next cycle.
// Throughput: one sample per cycle; the state update is one pass per cycle.
// The status register decouples the sides, so a sample is taken whenever the
// status register is empty or being drained.
// Reset (rst, synchronous): released level, counters and flags cleared,
// configuration back to enabled, 300 / 1000 / 100 ms.
// ----------------------------------------------------------------------------
module button_click_long_press_detector
  import bcl_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  bcl_stream_if.sink                sample,
  bcl_stream_if.source              status,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int WIDE_BITS = 16;

  logic                     enabled;
  logic [CFG_DATA_BITS-1:0] click_window_ms;
  logic [CFG_DATA_BITS-1:0] long_press_ms;
  logic [CFG_DATA_BITS-1:0] repeat_ms;

  logic                  level_reg, level_reg_next;
  logic [TIME_BITS-1:0]  press_start_time, press_start_time_next;
  logic [TIME_BITS-1:0]  first_press_time, first_press_time_next;
  logic [COUNT_BITS-1:0] press_counter, press_counter_next;
  logic [COUNT_BITS-1:0] latched_clicks, latched_clicks_next;
  logic                  long_flag, long_flag_next;
  logic                  repeat_flag, repeat_flag_next;
  logic                  changed_next;

  logic                  out_valid;
  status_t               out_data;
  status_t               out_data_next;
  logic                  accept;

  logic [TIME_BITS-1:0]  since_first, since_start;
  logic                  window_over, long_over, repeat_over;
  logic [COUNT_BITS-1:0] count_base;
  logic [WIDE_BITS-1:0]  count_wide, clicks_wide;

  assign sample.ready = !out_valid || status.ready;
  assign accept       = sample.valid && sample.ready;
  assign status.valid = out_valid;
  assign status.data  = out_data;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b1;
      click_window_ms <= CLICK_WINDOW_RESET;
      long_press_ms   <= LONG_PRESS_RESET;
      repeat_ms       <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:      enabled         <= cfg_data[0];
        REG_CLICK_WINDOW: click_window_ms <= cfg_data;
        REG_LONG_PRESS:   long_press_ms   <= cfg_data;
        REG_REPEAT:       repeat_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign since_first = sample.data.now_ms - first_press_time;
  assign since_start = sample.data.now_ms - press_start_time;
  assign window_over = since_first > TIME_BITS'(click_window_ms);
  assign long_over   = since_start > TIME_BITS'(long_press_ms);
  assign repeat_over = since_start > TIME_BITS'(repeat_ms);

  always_comb begin
    level_reg_next        = level_reg;
    press_start_time_next = press_start_time;
    first_press_time_next = first_press_time;
    press_counter_next    = press_counter;
    latched_clicks_next   = latched_clicks;
    long_flag_next        = long_flag;
    repeat_flag_next      = repeat_flag;
    changed_next          = 1'b0;
    count_base            = press_counter;

    if (enabled) begin
      level_reg_next      = sample.data.pin_level;
      latched_clicks_next = '0;
      // click window close
      if ((press_counter != '0) && window_over) begin
        latched_clicks_next = press_counter;
        count_base          = '0;
        changed_next        = 1'b1;
      end
      press_counter_next = count_base;

      if (sample.data.pin_level) begin
        press_start_time_next = '0;
        long_flag_next        = 1'b0;
        repeat_flag_next      = 1'b0;
        if (!level_reg) begin
          changed_next = 1'b1;
        end
      end else if (level_reg) begin
        press_start_time_next = sample.data.now_ms;
        if (count_base != COUNT_MAX) begin
          press_counter_next = count_base + 1'b1;
        end
        if (press_counter_next == COUNT_BITS'(1)) begin
          first_press_time_next = sample.data.now_ms;
        end
        changed_next = 1'b1;
      end else if (!long_flag) begin
        if (long_over) begin
          long_flag_next        = 1'b1;
          press_start_time_next = sample.data.now_ms;
          changed_next          = 1'b1;
        end
      end else if (repeat_over) begin
        repeat_flag_next      = 1'b1;
        press_start_time_next = sample.data.now_ms;
        changed_next          = 1'b1;
      end
    end
  end

  assign count_wide  = WIDE_BITS'(press_counter_next);
  assign clicks_wide = WIDE_BITS'(latched_clicks_next);

  always_comb begin
    out_data_next.changed      = changed_next;
    out_data_next.pressed      = !level_reg_next;
    out_data_next.press_count  = count_wide[OUT_COUNT_BITS-1:0];
    out_data_next.click_count  = clicks_wide[OUT_COUNT_BITS-1:0];
    out_data_next.long_pressed = long_flag_next;
    out_data_next.repeated     = repeat_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg        <= 1'b1;
      press_start_time <= '0;
      first_press_time <= '0;
      press_counter    <= '0;
      latched_clicks   <= '0;
      long_flag        <= 1'b0;
      repeat_flag      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        level_reg        <= level_reg_next;
        press_start_time <= press_start_time_next;
        first_press_time <= first_press_time_next;
        press_counter    <= press_counter_next;
        latched_clicks   <= latched_clicks_next;
        long_flag        <= long_flag_next;
        repeat_flag      <= repeat_flag_next;
        out_valid        <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  // checks
  a_no_flags_when_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pressed |-> !out_data.long_pressed && !out_data.repeated)
    else $error("long or repeat flag set while released");

  a_repeat_needs_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.repeated |-> out_data.long_pressed)
    else $error("repeat flag without long press");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.ready |-> !sample.ready)
    else $error("sample taken while status is stalled");

  a_accept_gives_status: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("sample transaction without status");

endmodule
